/* hdl/sph_cubic_spline_kernel_assert.svh */
// ----------------------------------------------------------------------------
// SPH cubic spline kernel assertion macros
// Shared concurrent assertion wrappers for the kernel RTL.
// ----------------------------------------------------------------------------
`ifndef SPH_CUBIC_SPLINE_KERNEL_ASSERT_SVH
`define SPH_CUBIC_SPLINE_KERNEL_ASSERT_SVH

// same-cycle implication
`define SPH_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define SPH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hdl/sph_pkg.sv */
// ----------------------------------------------------------------------------
// SPH kernel package
// Shared types and constants for the cubic spline kernel pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sph_pkg;

   // partial product chunk width of the multiplier pipelines
   localparam int CHUNK_W = 32;

   // 4 * pi * 2^60, rounded pi constant shifted by two
   localparam int          PIQ4_W   = 64;
   localparam logic [63:0] PIQ4     = 64'hC90FDAA22168C234;
   localparam int          PI_SHIFT = 60;

   typedef struct packed {
      logic bad_width;
      logic outside;
      logic near;
      logic sat;
   } flags_type;

   localparam int FLAGS_W = $bits(flags_type);

endpackage

/* hdl/sph_front.sv */
// ----------------------------------------------------------------------------
// SPH kernel front stage
// Classifies r against h and forms the spline operands x and y.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sph_front import sph_pkg::*; #(
   parameter int W = 32
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  logic [W-1:0]   in_r,
   input  logic [W-1:0]   in_h,
   output logic           out_valid,
   input  logic           out_ready,
   output logic [W-1:0]   out_h,
   output logic [W:0]     out_x,
   output logic [W+2:0]   out_y,
   output flags_type      out_flags
);

   localparam int XW = W + 1;
   localparam int YW = W + 3;

   logic            v_ff;
   logic [W-1:0]    h_ff;
   logic [XW-1:0]   x_ff, x_in;
   logic [YW-1:0]   y_ff, y_in;
   flags_type       flags_ff, flags_in;
   logic [XW-1:0]   u;

   assign in_ready = ~v_ff | out_ready;

   always_comb begin
      u                  = {in_h, 1'b0} - XW'(in_r);
      flags_in.bad_width = (in_h == '0);
      flags_in.outside   = (XW'(in_r) >= {in_h, 1'b0});
      flags_in.near      = (in_r < in_h);
      flags_in.sat       = 1'b0;
      if (flags_in.near) begin
         x_in = XW'(in_r);
         y_in = (YW'(in_h) << 2) + (YW'(in_h) << 1) - (YW'(in_r) << 1) - YW'(in_r);
      end else begin
         x_in = u;
         y_in = YW'(u);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         h_ff     <= in_h;
         x_ff     <= x_in;
         y_ff     <= y_in;
         flags_ff <= flags_in;
      end
   end

   assign out_valid = v_ff;
   assign out_h     = h_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_flags = flags_ff;

endmodule

/* hdl/sph_mul_pipe.sv */
// ----------------------------------------------------------------------------
// SPH chunked multiplier pipeline
// Multiplies two operands one chunk-by-chunk partial product per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sph_mul_pipe import sph_pkg::*; #(
   parameter int AW = 32,
   parameter int BW = 32,
   parameter int PW = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [AW-1:0]    in_a,
   input  logic [BW-1:0]    in_b,
   input  logic [PW-1:0]    in_pay,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [AW+BW-1:0] out_p,
   output logic [PW-1:0]    out_pay
);

   localparam int NA   = (AW + CHUNK_W - 1) / CHUNK_W;
   localparam int NB   = (BW + CHUNK_W - 1) / CHUNK_W;
   localparam int NS   = NA * NB;
   localparam int PAW  = NA * CHUNK_W;
   localparam int PBW  = NB * CHUNK_W;
   localparam int ACCW = PAW + PBW;

   logic             v_ff     [NS];
   logic [PAW-1:0]   a_ff     [NS];
   logic [PBW-1:0]   b_ff     [NS];
   logic [ACCW-1:0]  acc_ff   [NS];
   logic [PW-1:0]    pay_ff   [NS];
   logic             st_ready [NS];

   for (genvar s = 0; s < NS; s++) begin : g_stage
      localparam int IA = s / NB;
      localparam int IB = s % NB;

      logic               v_src;
      logic [PAW-1:0]     a_src;
      logic [PBW-1:0]     b_src;
      logic [ACCW-1:0]    acc_src;
      logic [PW-1:0]      pay_src;
      logic               nxt_ready;
      logic [2*CHUNK_W-1:0] pp;
      logic [ACCW-1:0]    acc_in;

      if (s == 0) begin : g_first
         assign v_src   = in_valid;
         assign a_src   = PAW'(in_a);
         assign b_src   = PBW'(in_b);
         assign acc_src = '0;
         assign pay_src = in_pay;
      end else begin : g_next
         assign v_src   = v_ff[s-1];
         assign a_src   = a_ff[s-1];
         assign b_src   = b_ff[s-1];
         assign acc_src = acc_ff[s-1];
         assign pay_src = pay_ff[s-1];
      end

      if (s == NS - 1) begin : g_last
         assign nxt_ready = out_ready;
      end else begin : g_mid
         assign nxt_ready = st_ready[s+1];
      end

      assign st_ready[s] = ~v_ff[s] | nxt_ready;
      assign pp     = a_src[IA*CHUNK_W +: CHUNK_W] * b_src[IB*CHUNK_W +: CHUNK_W];
      assign acc_in = acc_src + (ACCW'(pp) << ((IA + IB) * CHUNK_W));

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (st_ready[s]) begin
            v_ff[s] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (st_ready[s]) begin
            a_ff[s]   <= a_src;
            b_ff[s]   <= b_src;
            acc_ff[s] <= acc_in;
            pay_ff[s] <= pay_src;
         end
      end
   end

   assign in_ready  = st_ready[0];
   assign out_valid = v_ff[NS-1];
   assign out_p     = acc_ff[NS-1][AW+BW-1:0];
   assign out_pay   = pay_ff[NS-1];

endmodule

/* hdl/sph_divider.sv */
// ----------------------------------------------------------------------------
// SPH kernel divider
// Overflow check followed by one restoring quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sph_divider import sph_pkg::*; #(
   parameter int W    = 32,
   parameter int BW   = 256,
   parameter int NUMW = 98,
   parameter int SH   = 92
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  logic [NUMW-1:0] in_num,
   input  logic [BW-1:0]   in_div,
   input  flags_type       in_flags,
   output logic            out_valid,
   input  logic            out_ready,
   output logic [W-1:0]    out_q,
   output flags_type       out_flags
);

   localparam int CMPW = ((NUMW + SH) > BW) ? (NUMW + SH) : BW;

   logic            v_ff     [W+1];
   logic [BW-1:0]   rem_ff   [W+1];
   logic [BW-1:0]   div_ff   [W+1];
   logic [W-1:0]    q_ff     [W+1];
   flags_type       flags_ff [W+1];
   logic            st_ready [W+1];

   for (genvar j = 0; j <= W; j++) begin : g_stage
      logic            v_src;
      logic            nxt_ready;
      logic [BW-1:0]   rem_in;
      logic [BW-1:0]   div_src;
      logic [W-1:0]    q_in;
      flags_type       flags_in;

      if (j == W) begin : g_last
         assign nxt_ready = out_ready;
      end else begin : g_mid
         assign nxt_ready = st_ready[j+1];
      end

      if (j == 0) begin : g_sat
         logic [CMPW-1:0] wide;
         assign v_src   = in_valid;
         assign div_src = in_div;
         assign wide    = CMPW'(in_num) << SH;
         assign rem_in  = wide[BW-1:0];
         assign q_in    = '0;
         always_comb begin
            flags_in     = in_flags;
            flags_in.sat = (wide >= CMPW'(in_div));
         end
      end else begin : g_bit
         localparam int K = W - j;
         logic [BW:0] t;
         logic [BW:0] diff;
         logic        ge;
         assign v_src    = v_ff[j-1];
         assign div_src  = div_ff[j-1];
         assign flags_in = flags_ff[j-1];
         assign t        = {rem_ff[j-1], 1'b0};
         assign diff     = t - {1'b0, div_ff[j-1]};
         assign ge       = (t >= {1'b0, div_ff[j-1]});
         assign rem_in   = ge ? diff[BW-1:0] : t[BW-1:0];
         assign q_in     = q_ff[j-1] | (W'(ge) << K);
      end

      assign st_ready[j] = ~v_ff[j] | nxt_ready;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (st_ready[j]) begin
            v_ff[j] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (st_ready[j]) begin
            rem_ff[j]   <= rem_in;
            div_ff[j]   <= div_src;
            q_ff[j]     <= q_in;
            flags_ff[j] <= flags_in;
         end
      end
   end

   assign in_ready  = st_ready[0];
   assign out_valid = v_ff[W];
   assign out_q     = q_ff[W];
   assign out_flags = flags_ff[W];

endmodule

/* hdl/sph_cubic_spline_kernel.sv */
// ----------------------------------------------------------------------------
// SPH cubic spline kernel
// Evaluates W(r,h) = f(r/h) / (pi h^3) for the M4 spline in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item: distance r and smoothing length h, unsigned
//   fixed point with FRAC_BITS fraction bits. rsp_* returns W(r,h) in the
//   same format with a saturated flag and a bad_width flag (h == 0).
//   The result is floor-rounded from the exact rational value.
// Throughput: one item per cycle while rsp_tready is high. Every stage holds
//   its own valid bit and moves whenever the stage after it is empty or moving,
//   so bubbles fill in while the receiver stalls.
// Stages: a front register, chunked multiplier stages (six products,
//   each ceil(a/32)*ceil(b/32) stages), a numerator register, an overflow
//   check, VALUE_WIDTH quotient-bit stages and an output register.
// Reset: synchronous, clears all valid bits; no other state.
// Stall: with rsp_tready low the result holds, the pipe fills up and
//   req_tready drops once no empty stage is left. Nothing is lost.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sph_cubic_spline_kernel_assert.svh"

module sph_cubic_spline_kernel import sph_pkg::*; #(
   parameter int VALUE_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // distance, smoothing_length, zero pad
   input  logic [((2*VALUE_WIDTH+7)/8)*8-1:0]  req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // kernel_value, zero pad
   output logic [((VALUE_WIDTH+7)/8)*8-1:0]    rsp_tdata,
   // saturated, bad_width
   output logic [1:0]                          rsp_tuser
);

   localparam int W    = VALUE_WIDTH;
   localparam int ODW  = ((W + 7) / 8) * 8;
   localparam int XW   = W + 1;
   localparam int YW   = W + 3;
   localparam int H2W  = 2 * W;
   localparam int H3W  = 3 * W;
   localparam int H6W  = 6 * W;
   localparam int BW   = H6W + PIQ4_W;
   localparam int X2W  = 2 * XW;
   localparam int XYW  = X2W + YW;
   localparam int NUMW = 3 * W + 2;
   localparam int SH   = 4 * FRAC_BITS + PI_SHIFT - W;
   localparam int P_A  = XW + YW + FLAGS_W + W;
   localparam int P_B  = XW + YW + FLAGS_W + H3W;
   localparam int P_C  = YW + FLAGS_W + H3W + BW;
   localparam int P_D  = FLAGS_W + H3W + BW;

   // front
   logic            front_valid, front_ready;
   logic [W-1:0]    front_h;
   logic [XW-1:0]   front_x;
   logic [YW-1:0]   front_y;
   flags_type       front_flags;

   sph_front #(.W(W)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_r      (req_tdata[W-1:0]),
      .in_h      (req_tdata[2*W-1:W]),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_h     (front_h),
      .out_x     (front_x),
      .out_y     (front_y),
      .out_flags (front_flags)
   );

   // h^2
   logic             m1_valid, m1_ready;
   logic [H2W-1:0]   m1_p;
   logic [P_A-1:0]   m1_pay;

   sph_mul_pipe #(.AW(W), .BW(W), .PW(P_A)) u_mul_h2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_a      (front_h),
      .in_b      (front_h),
      .in_pay    ({front_x, front_y, front_flags, front_h}),
      .out_valid (m1_valid),
      .out_ready (m1_ready),
      .out_p     (m1_p),
      .out_pay   (m1_pay)
   );

   // h^3
   logic             m2_valid, m2_ready;
   logic [H3W-1:0]   m2_p;
   logic [P_A-1:0]   m2_pay;

   sph_mul_pipe #(.AW(H2W), .BW(W), .PW(P_A)) u_mul_h3 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m1_valid),
      .in_ready  (m1_ready),
      .in_a      (m1_p),
      .in_b      (m1_pay[W-1:0]),
      .in_pay    (m1_pay),
      .out_valid (m2_valid),
      .out_ready (m2_ready),
      .out_p     (m2_p),
      .out_pay   (m2_pay)
   );

   // h^6
   logic             m3_valid, m3_ready;
   logic [H6W-1:0]   m3_p;
   logic [P_B-1:0]   m3_pay;

   sph_mul_pipe #(.AW(H3W), .BW(H3W), .PW(P_B)) u_mul_h6 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m2_valid),
      .in_ready  (m2_ready),
      .in_a      (m2_p),
      .in_b      (m2_p),
      .in_pay    ({m2_pay[P_A-1:W], m2_p}),
      .out_valid (m3_valid),
      .out_ready (m3_ready),
      .out_p     (m3_p),
      .out_pay   (m3_pay)
   );

   // divisor 4 pi h^6
   logic             m4_valid, m4_ready;
   logic [BW-1:0]    m4_p;
   logic [P_B-1:0]   m4_pay;

   sph_mul_pipe #(.AW(H6W), .BW(PIQ4_W), .PW(P_B)) u_mul_pi (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m3_valid),
      .in_ready  (m3_ready),
      .in_a      (m3_p),
      .in_b      (PIQ4),
      .in_pay    (m3_pay),
      .out_valid (m4_valid),
      .out_ready (m4_ready),
      .out_p     (m4_p),
      .out_pay   (m4_pay)
   );

   // x^2
   logic             m5_valid, m5_ready;
   logic [X2W-1:0]   m5_p;
   logic [P_C-1:0]   m5_pay;

   sph_mul_pipe #(.AW(XW), .BW(XW), .PW(P_C)) u_mul_x2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m4_valid),
      .in_ready  (m4_ready),
      .in_a      (m4_pay[P_B-1 -: XW]),
      .in_b      (m4_pay[P_B-1 -: XW]),
      .in_pay    ({m4_pay[P_B-XW-1:0], m4_p}),
      .out_valid (m5_valid),
      .out_ready (m5_ready),
      .out_p     (m5_p),
      .out_pay   (m5_pay)
   );

   // x^2 y
   logic             m6_valid, m6_ready;
   logic [XYW-1:0]   m6_p;
   logic [P_D-1:0]   m6_pay;

   sph_mul_pipe #(.AW(X2W), .BW(YW), .PW(P_D)) u_mul_xy (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m5_valid),
      .in_ready  (m5_ready),
      .in_a      (m5_p),
      .in_b      (m5_pay[P_C-1 -: YW]),
      .in_pay    (m5_pay[P_D-1:0]),
      .out_valid (m6_valid),
      .out_ready (m6_ready),
      .out_p     (m6_p),
      .out_pay   (m6_pay)
   );

   // numerator stage
   logic             num_v_ff;
   logic [NUMW-1:0]  num_ff, num_in;
   logic [BW-1:0]    div_ff;
   flags_type        nflags_ff, nflags_in;
   logic [H3W-1:0]   h3;
   logic             num_ready, div_in_ready;

   assign nflags_in = flags_type'(m6_pay[P_D-1 -: FLAGS_W]);
   assign h3        = m6_pay[BW +: H3W];
   assign num_in    = nflags_in.near ? (NUMW'(h3) << 2) - NUMW'(m6_p) : NUMW'(m6_p);
   assign num_ready = ~num_v_ff | div_in_ready;
   assign m6_ready  = num_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_v_ff <= 1'b0;
      end else if (num_ready) begin
         num_v_ff <= m6_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (num_ready) begin
         num_ff    <= num_in;
         div_ff    <= m6_pay[BW-1:0];
         nflags_ff <= nflags_in;
      end
   end

   // quotient
   logic             dv_valid, dv_ready;
   logic [W-1:0]     dv_q;
   flags_type        dv_flags;

   sph_divider #(.W(W), .BW(BW), .NUMW(NUMW), .SH(SH)) u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (num_v_ff),
      .in_ready  (div_in_ready),
      .in_num    (num_ff),
      .in_div    (div_ff),
      .in_flags  (nflags_ff),
      .out_valid (dv_valid),
      .out_ready (dv_ready),
      .out_q     (dv_q),
      .out_flags (dv_flags)
   );

   // output register
   logic             rsp_v_ff;
   logic [W-1:0]     kv_ff, kv_in;
   logic             sat_ff, sat_in;
   logic             bad_ff;

   assign dv_ready = ~rsp_v_ff | rsp_tready;

   always_comb begin
      sat_in = dv_flags.sat & ~dv_flags.bad_width & ~dv_flags.outside;
      if (dv_flags.bad_width || dv_flags.outside) begin
         kv_in = '0;
      end else if (dv_flags.sat) begin
         kv_in = '1;
      end else begin
         kv_in = dv_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (dv_ready) begin
         rsp_v_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (dv_ready) begin
         kv_ff  <= kv_in;
         sat_ff <= sat_in;
         bad_ff <= dv_flags.bad_width;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = ODW'(kv_ff);
   assign rsp_tuser  = {bad_ff, sat_ff};

   `SPH_ASSERT_IMPL(a_bad_zero, clock, reset, rsp_tvalid && bad_ff, kv_ff == '0 && !sat_ff)
   `SPH_ASSERT_IMPL(a_sat_ones, clock, reset, rsp_tvalid && sat_ff, (&kv_ff) && !bad_ff)
   `SPH_ASSERT_NEXT(a_enter, clock, reset, req_tvalid && req_tready, front_valid)

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// SPH cubic spline kernel testbench
// Streams distance/width pairs through the kernel with random idling and a
// long result stall. Typed rows are checked against their given result, all
// others against an exact wide-integer model of the spline value over pi h^3.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int VW        = 32;
   localparam int FB        = 16;
   localparam int N_RANDOM  = 1300;
   localparam int DRAIN_CYC = 100;
   localparam logic [63:0] PI_FIXED = 64'h3243F6A8885A308D;

   typedef struct {
      logic [VW-1:0] kernel_value;
      logic          saturated;
      logic          bad_width;
   } kernel_result_type;

   typedef struct {
      logic [VW-1:0]     distance;
      logic [VW-1:0]     smoothing_length;
      bit                typed;
      kernel_result_type want;
   } pair_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [2*VW-1:0]    req_tdata = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [VW-1:0]      rsp_tdata;
   logic [1:0]         rsp_tuser;

   kernel_result_type  pending_values[$];
   int                 n_errors = 0;
   int                 n_results = 0;
   int                 n_saturated = 0;
   int                 n_zero_width = 0;
   bit                 quiet_stretch = 1'b0;

   always #5 clock = ~clock;

   sph_cubic_spline_kernel #(.VALUE_WIDTH(VW), .FRAC_BITS(FB)) dut (.*);

   function automatic kernel_result_type spline_kernel_value(logic [VW-1:0] r,
                                                             logic [VW-1:0] h);
      kernel_result_type res;
      logic [511:0]      rw, hw, h3, num, p, d, q;
      res = '{kernel_value: '0, saturated: 1'b0, bad_width: 1'b0};
      if (h == 0) begin
         res.bad_width = 1'b1;
         return res;
      end
      rw = r;
      hw = h;
      if (rw >= 2 * hw) return res;
      h3 = hw * hw * hw;
      if (rw < hw) num = 4 * h3 + 3 * rw * rw * rw - 6 * rw * rw * hw;
      else num = (2 * hw - rw) * (2 * hw - rw) * (2 * hw - rw);
      p = num << (4 * FB + 60);
      d = (h3 * h3 * PI_FIXED) << 2;
      q = p / d;
      if (q >> VW != 0) begin
         res.kernel_value = '1;
         res.saturated    = 1'b1;
      end else begin
         res.kernel_value = q[VW-1:0];
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [VW-1:0] got, logic [VW-1:0] want);
      $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
      n_errors++;
   endtask

   task automatic send_pair(logic [VW-1:0] r, logic [VW-1:0] h, bit typed,
                            kernel_result_type want);
      req_tvalid <= 1'b1;
      req_tdata  <= {h, r};
      do @(posedge clock); while (!req_tready);
      pending_values.push_back(typed ? want : spline_kernel_value(r, h));
      while (!quiet_stretch && $urandom_range(0, 99) < 32) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // result side: random stall, one long hold-off while items keep coming
   initial begin
      kernel_result_type exp_r;
      int hold;
      bit held = 1'b0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            n_results++;
            if (pending_values.size() == 0) begin
               report_mismatch("unexpected item", rsp_tdata, '0);
            end else begin
               exp_r = pending_values.pop_front();
               if (rsp_tdata !== exp_r.kernel_value)
                  report_mismatch("kernel_value", rsp_tdata, exp_r.kernel_value);
               if (rsp_tuser[0] !== exp_r.saturated)
                  report_mismatch("saturated", rsp_tuser[0], exp_r.saturated);
               if (rsp_tuser[1] !== exp_r.bad_width)
                  report_mismatch("bad_width", rsp_tuser[1], exp_r.bad_width);
               if (exp_r.saturated) n_saturated++;
               if (exp_r.bad_width) n_zero_width++;
            end
         end
         if (!held && n_results == 150) begin
            held = 1'b1;
            hold = 300;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet_stretch || $urandom_range(0, 99) >= 32;
         end
      end
   end

   initial begin
      #5ms;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      pair_row_type      rows[$];
      kernel_result_type none;
      logic [VW-1:0]     r, h;
      logic [VW:0]       span;
      int                mode;
      none = '{kernel_value: '0, saturated: 1'b0, bad_width: 1'b0};

      // zero width, outside support, overflow, extremes, both spline branches
      rows.push_back('{32'h0000_0000, 32'h0000_0000, 1, '{0, 0, 1}});
      rows.push_back('{32'hFFFF_FFFF, 32'h0000_0000, 1, '{0, 0, 1}});
      rows.push_back('{32'h0002_0000, 32'h0001_0000, 1, '{0, 0, 0}});
      rows.push_back('{32'hFFFF_FFFF, 32'h0000_0001, 1, '{0, 0, 0}});
      rows.push_back('{32'hFFFF_FFFF, 32'h7FFF_FFFF, 1, '{0, 0, 0}});
      rows.push_back('{32'h0000_0000, 32'h0000_0001, 1, '{32'hFFFF_FFFF, 1, 0}});
      rows.push_back('{32'h0000_0001, 32'h0000_0001, 1, '{32'hFFFF_FFFF, 1, 0}});
      rows.push_back('{32'h0000_0000, 32'h0001_0000, 0, none});
      rows.push_back('{32'h0000_8000, 32'h0001_0000, 0, none});
      rows.push_back('{32'h0000_FFFF, 32'h0001_0000, 0, none});
      rows.push_back('{32'h0001_0000, 32'h0001_0000, 0, none});
      rows.push_back('{32'h0001_8000, 32'h0001_0000, 0, none});
      rows.push_back('{32'h0001_FFFF, 32'h0001_0000, 0, none});
      rows.push_back('{32'h0000_0000, 32'hFFFF_FFFF, 0, none});
      rows.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, none});
      rows.push_back('{32'hFFFF_FFFE, 32'h8000_0000, 0, none});
      rows.push_back('{32'h0000_0000, 32'h0000_0100, 0, none});
      rows.push_back('{32'h0000_0000, 32'h0000_0200, 0, none});
      rows.push_back('{32'h0000_0000, 32'h0000_0080, 0, none});

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i])
         send_pair(rows[i].distance, rows[i].smoothing_length, rows[i].typed, rows[i].want);

      for (int n = 0; n < N_RANDOM; n++) begin
         quiet_stretch = (n >= 500 && n < 800);
         h    = $urandom >> $urandom_range(0, 31);
         if ($urandom_range(0, 19) == 0) h = 0;
         span = 2 * {1'b0, h};
         mode = $urandom_range(0, 9);
         if (h == 0 || mode >= 8) r = $urandom;
         else if (mode >= 6) r = (mode == 6 ? h : span[VW-1:0]) + $urandom_range(0, 2) - 1;
         else r = (span > {1'b0, {VW{1'b1}}}) ? $urandom : $urandom_range(0, span - 1);
         send_pair(r, h, 0, none);
      end
      req_tvalid <= 1'b0;

      while (pending_values.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);

      $display("Checked %0d kernel evaluations: %0d saturated, %0d with zero width.",
               n_results, n_saturated, n_zero_width);
      $display("Covered both spline branches, the support edge and a long output stall.");
      if (n_errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
